/* sv/rvm_exec_pkg.sv */
// ----------------------------------------------------------------------------
// rvm_exec_pkg
// Opcodes, sequencer states and shared types of the integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvm_exec_pkg;

   localparam int OP_BITS        = 4;
   localparam int REG_FIELD_BITS = 5;
   localparam int WORD_BITS      = 64;
   localparam int TARGET_BITS    = 12;
   localparam int NEXT_IP_BITS   = 13;
   localparam int PC_STEP        = 4;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD  = 4'd0,
      OP_ADDI = 4'd1,
      OP_SUB  = 4'd2,
      OP_MUL  = 4'd3,
      OP_DIV  = 4'd4,
      OP_REM  = 4'd5,
      OP_JUMP = 4'd6,
      OP_BEQ  = 4'd7,
      OP_BNE  = 4'd8,
      OP_BLT  = 4'd9,
      OP_BGE  = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      EX_IDLE,
      EX_EXEC,
      EX_WAIT,
      EX_COMMIT
   } ex_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef enum logic [1:0] {
      MD_KIND_MUL,
      MD_KIND_DIV,
      MD_KIND_REM
   } md_kind_type;

   typedef struct packed {
      logic        start;
      md_kind_type kind;
   } md_cmd_type;

endpackage

`default_nettype wire

/* sv/rvm_exec_muldiv.sv */
// ----------------------------------------------------------------------------
// rvm_exec_muldiv
// Multicycle multiply (half-width partial products) and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rvm_exec_muldiv
   import rvm_exec_pkg::*;
#(
   parameter int DATA_BITS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire md_cmd_type           cmd,
   input  wire logic [DATA_BITS-1:0] op_a,
   input  wire logic [DATA_BITS-1:0] op_b,
   output logic                      done,
   output logic [DATA_BITS-1:0]      result
);

   localparam int HALF     = (DATA_BITS + 1) / 2;
   localparam int W2       = 2 * HALF;
   localparam int CNT_BITS = $clog2(DATA_BITS);

   md_state_type          state_ff, state_in;
   md_kind_type           kind_ff;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [W2-1:0]         a_ff, b_ff;
   logic [W2-1:0]         prod_ff;
   logic [W2-1:0]         acc_ff;
   logic [HALF-1:0]       mul_x, mul_y;
   logic [W2-1:0]         mul_p;
   logic [DATA_BITS-1:0]  quo_ff, rem_ff;
   logic [DATA_BITS:0]    shifted;
   logic                  fits;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (cmd.start) begin
               state_in = (cmd.kind == MD_KIND_MUL) ? MD_MUL : MD_DIV;
            end
         end
         MD_MUL: begin
            if (cnt_ff == CNT_BITS'(3)) begin
               state_in = MD_IDLE;
               done_in  = 1'b1;
            end
         end
         MD_DIV: begin
            if (cnt_ff == CNT_BITS'(DATA_BITS - 1)) begin
               state_in = MD_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // partial product select: lo*lo, lo*hi, hi*lo
   always_comb begin
      mul_x = a_ff[HALF-1:0];
      mul_y = b_ff[HALF-1:0];
      case (cnt_ff)
         CNT_BITS'(1): mul_y = b_ff[W2-1:HALF];
         CNT_BITS'(2): mul_x = a_ff[W2-1:HALF];
         default: ;
      endcase
   end

   assign mul_p = mul_x * mul_y;

   assign shifted = {rem_ff, quo_ff[DATA_BITS-1]};
   assign fits    = (shifted >= {1'b0, b_ff[DATA_BITS-1:0]});

   always_ff @(posedge clock) begin
      if (state_ff == MD_IDLE) begin
         if (cmd.start) begin
            kind_ff <= cmd.kind;
            cnt_ff  <= '0;
            a_ff    <= W2'(op_a);
            b_ff    <= W2'(op_b);
            quo_ff  <= op_a;
            rem_ff  <= '0;
            acc_ff  <= '0;
         end
      end else begin
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
      if (state_ff == MD_MUL) begin
         prod_ff <= mul_p;
         case (cnt_ff)
            CNT_BITS'(0): ;
            CNT_BITS'(1): acc_ff <= prod_ff;
            default:      acc_ff <= acc_ff + (prod_ff << HALF);
         endcase
      end
      if (state_ff == MD_DIV) begin
         quo_ff <= {quo_ff[DATA_BITS-2:0], fits};
         rem_ff <= fits ? DATA_BITS'(shifted - {1'b0, b_ff[DATA_BITS-1:0]})
                        : shifted[DATA_BITS-1:0];
      end
   end

   assign done   = done_ff;
   assign result = (kind_ff == MD_KIND_MUL) ? acc_ff[DATA_BITS-1:0] :
                   (kind_ff == MD_KIND_DIV) ? quo_ff : rem_ff;

endmodule

`default_nettype wire

/* sv/register_vm_execute_unit_top.sv */
// ----------------------------------------------------------------------------
// register_vm_execute_unit_top
// Executes one decoded instruction per transfer against a register file.
// ----------------------------------------------------------------------------
// One instruction is in flight at a time. The register file is a memory with
// a registered two-port read, so add, addi, sub, jump and the branches are
// accepted with the read, then executed and written back once the output
// register is free. Multiply runs four steps of a shared half-width
// multiplier; divide and remainder run the one-bit-per-cycle restoring
// divider. A finished result waits in the output register while the next
// instruction is accepted. Each register-file entry has a valid bit that
// reset clears, so an unwritten register reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module register_vm_execute_unit_top
   import rvm_exec_pkg::*;
#(
   parameter int REGISTER_COUNT = 32,
   parameter int PROGRAM_WORDS  = 4096,
   parameter int DATA_BITS      = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [OP_BITS-1:0]        req_operation,
   input  wire logic [REG_FIELD_BITS-1:0] req_dest_reg,
   input  wire logic [REG_FIELD_BITS-1:0] req_src1_reg,
   input  wire logic [REG_FIELD_BITS-1:0] req_src2_reg,
   input  wire logic [WORD_BITS-1:0]      req_immediate,
   input  wire logic [TARGET_BITS-1:0]    req_jump_target,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [NEXT_IP_BITS-1:0]        rsp_next_ip,
   output logic                           rsp_taken,
   output logic                           rsp_wrote,
   output logic [WORD_BITS-1:0]           rsp_write_value,
   output logic                           rsp_fault
);

   localparam int IDX_BITS = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam int PC_BITS  = $clog2(PROGRAM_WORDS + 1);

   function automatic logic [IDX_BITS-1:0] reg_idx(input logic [REG_FIELD_BITS-1:0] f);
      logic [10:0] r;
      r = 11'(f);
      for (int k = 4; k >= 0; k--) begin
         if (r >= 11'(REGISTER_COUNT << k)) begin
            r = r - 11'(REGISTER_COUNT << k);
         end
      end
      return r[IDX_BITS-1:0];
   endfunction

   ex_state_type          state_ff, state_in;
   op_type                op_ff;
   logic [IDX_BITS-1:0]   dest_ff;
   logic [DATA_BITS-1:0]  imm_ff;
   logic [TARGET_BITS-1:0] target_ff;
   logic [PC_BITS-1:0]    pc_ff;

   logic [DATA_BITS-1:0]  rf_mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] rf_ok_ff;
   logic [DATA_BITS-1:0]  rd1_ff, rd2_ff;
   logic                  rd1_ok_ff, rd2_ok_ff;

   logic                  rsp_valid_ff;
   logic [NEXT_IP_BITS-1:0] rsp_next_ip_ff;
   logic                  rsp_taken_ff, rsp_wrote_ff, rsp_fault_ff;
   logic [WORD_BITS-1:0]  rsp_write_value_ff;

   logic                  accept, slot_free, commit;
   logic [DATA_BITS-1:0]  a, b, value, value_fin;
   logic                  wrote, taken, fault, md_need;
   md_kind_type           md_kind;
   md_cmd_type            md_cmd;
   logic                  md_done;
   logic [DATA_BITS-1:0]  md_result;
   logic [31:0]           pc_plus, adv_wide, tgt_wide, next_wide;
   logic [PC_BITS-1:0]    next_pc;

   assign req_stall = (state_ff != EX_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign a = rd1_ok_ff ? rd1_ff : '0;
   assign b = rd2_ok_ff ? rd2_ff : '0;

   always_comb begin
      value   = '0;
      wrote   = 1'b0;
      taken   = 1'b0;
      fault   = 1'b0;
      md_need = 1'b0;
      md_kind = MD_KIND_MUL;
      case (op_ff)
         OP_ADD: begin
            value = a + b;
            wrote = 1'b1;
         end
         OP_ADDI: begin
            value = a + imm_ff;
            wrote = 1'b1;
         end
         OP_SUB: begin
            value = a - b;
            wrote = 1'b1;
         end
         OP_MUL: begin
            md_need = 1'b1;
            wrote   = 1'b1;
         end
         OP_DIV, OP_REM: begin
            if (b == '0) begin
               fault = 1'b1;
            end else begin
               md_need = 1'b1;
               md_kind = (op_ff == OP_DIV) ? MD_KIND_DIV : MD_KIND_REM;
               wrote   = 1'b1;
            end
         end
         OP_JUMP: taken = 1'b1;
         OP_BEQ:  taken = (a == b);
         OP_BNE:  taken = (a != b);
         OP_BLT:  taken = (a < b);
         OP_BGE:  taken = (a >= b);
         default: fault = 1'b1;
      endcase
   end

   assign value_fin = (state_ff == EX_COMMIT) ? md_result : value;

   assign pc_plus  = 32'(pc_ff) + 32'(PC_STEP);
   assign adv_wide = (pc_plus > 32'(PROGRAM_WORDS)) ? 32'(PROGRAM_WORDS) : pc_plus;
   assign tgt_wide = (32'(target_ff) > 32'(PROGRAM_WORDS)) ? 32'(PROGRAM_WORDS)
                                                           : 32'(target_ff);
   assign next_wide = fault ? 32'(pc_ff) : (taken ? tgt_wide : adv_wide);
   assign next_pc   = next_wide[PC_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      commit     = 1'b0;
      md_cmd     = '{start: 1'b0, kind: md_kind};
      case (state_ff)
         EX_IDLE: begin
            if (req_valid) begin
               state_in = EX_EXEC;
            end
         end
         EX_EXEC: begin
            if (md_need) begin
               md_cmd.start = 1'b1;
               state_in     = EX_WAIT;
            end else if (slot_free) begin
               commit   = 1'b1;
               state_in = EX_IDLE;
            end
         end
         EX_WAIT: begin
            if (md_done) begin
               state_in = EX_COMMIT;
            end
         end
         EX_COMMIT: begin
            if (slot_free) begin
               commit   = 1'b1;
               state_in = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_IDLE;
         pc_ff        <= '0;
         rf_ok_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            pc_ff <= next_pc;
         end
         if (commit && wrote) begin
            rf_ok_ff[dest_ff] <= 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // register file: two registered reads at accept, one write at commit
   always_ff @(posedge clock) begin
      if (accept) begin
         rd1_ff    <= rf_mem[reg_idx(req_src1_reg)];
         rd2_ff    <= rf_mem[reg_idx(req_src2_reg)];
         rd1_ok_ff <= rf_ok_ff[reg_idx(req_src1_reg)];
         rd2_ok_ff <= rf_ok_ff[reg_idx(req_src2_reg)];
      end
      if (commit && wrote) begin
         rf_mem[dest_ff] <= value_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_operation);
         dest_ff   <= reg_idx(req_dest_reg);
         imm_ff    <= req_immediate[DATA_BITS-1:0];
         target_ff <= req_jump_target;
      end
      if (commit) begin
         rsp_next_ip_ff     <= next_wide[NEXT_IP_BITS-1:0];
         rsp_taken_ff       <= taken;
         rsp_wrote_ff       <= wrote;
         rsp_write_value_ff <= WORD_BITS'(value_fin);
         rsp_fault_ff       <= fault;
      end
   end

   rvm_exec_muldiv #(
      .DATA_BITS(DATA_BITS)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md_cmd),
      .op_a   (a),
      .op_b   (b),
      .done   (md_done),
      .result (md_result)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_ip     = rsp_next_ip_ff;
   assign rsp_taken       = rsp_taken_ff;
   assign rsp_wrote       = rsp_wrote_ff;
   assign rsp_write_value = rsp_write_value_ff;
   assign rsp_fault       = rsp_fault_ff;

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("commit did not load the result register");

   a_pc_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(pc_ff) <= 32'(PROGRAM_WORDS))
      else $error("program counter past end of program");

   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == EX_WAIT))
      else $error("muldiv finished outside of wait state");

   a_rf_write_at_exec: assert property (@(posedge clock) disable iff (reset)
      (commit && wrote) |-> (state_ff == EX_EXEC || state_ff == EX_COMMIT))
      else $error("register file written outside of execute");

endmodule

`default_nettype wire

/* verif/register_vm_execute_unit_top_test.sv */
// ----------------------------------------------------------------------------
// register_vm_execute_unit_top_test
// Self-checking testbench for the integer execute unit.
// ----------------------------------------------------------------------------
// A short table of directed instructions covers the operand extremes, every
// opcode, unused opcodes, division by zero, counter saturation and branches
// taken and not taken. About 700 random instructions follow. Every result
// transfer is compared field by field against its typed table outcome or an in-order
// shadow of the register file and program counter. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module register_vm_execute_unit_top_test
   import rvm_exec_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REG_COUNT    = 32;
   localparam int PROGRAM_END  = 4096;
   localparam int DATA_WIDTH   = 64;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = 150;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic [OP_BITS-1:0]   OP_FIRST_UNUSED = 4'd11;
   localparam logic [OP_BITS-1:0]   OP_LAST_UNUSED  = 4'd15;
   localparam logic [WORD_BITS-1:0] ALL_ONES        = '1;
   localparam logic [WORD_BITS-1:0] TOP_BIT         = 64'h8000_0000_0000_0000;
   localparam logic [WORD_BITS-1:0] STRIPES         = 64'h5a5a_5a5a_5a5a_5a5a;

   typedef struct packed {
      logic [OP_BITS-1:0]        op;
      logic [REG_FIELD_BITS-1:0] dest;
      logic [REG_FIELD_BITS-1:0] src1;
      logic [REG_FIELD_BITS-1:0] src2;
      logic [WORD_BITS-1:0]      imm;
      logic [TARGET_BITS-1:0]    target;
   } instr_type;

   typedef struct packed {
      logic [NEXT_IP_BITS-1:0] next_ip;
      logic                    taken;
      logic                    wrote;
      logic [WORD_BITS-1:0]    value;
      logic                    fault;
   } outcome_type;

   typedef struct packed {
      instr_type   ins;
      logic        typed;
      outcome_type outcome;
   } stim_row_type;

   localparam outcome_type NO_OUTCOME = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_BITS-1:0]        req_operation = '0;
   logic [REG_FIELD_BITS-1:0] req_dest_reg = '0;
   logic [REG_FIELD_BITS-1:0] req_src1_reg = '0;
   logic [REG_FIELD_BITS-1:0] req_src2_reg = '0;
   logic [WORD_BITS-1:0]      req_immediate = '0;
   logic [TARGET_BITS-1:0]    req_jump_target = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [NEXT_IP_BITS-1:0]   rsp_next_ip;
   logic                      rsp_taken;
   logic                      rsp_wrote;
   logic [WORD_BITS-1:0]      rsp_write_value;
   logic                      rsp_fault;

   logic [WORD_BITS-1:0]    arch_regs [REG_COUNT];
   logic [NEXT_IP_BITS-1:0] arch_pc;

   outcome_type  pending_results[$];
   stim_row_type directed_rows[$];
   int unsigned  send_idle_pct = 19;
   int unsigned  recv_idle_pct = 58;
   int           issued_count = 0;
   int           checked_count = 0;
   int           fault_count = 0;
   int           taken_count = 0;
   int           fail_count = 0;
   int           cycle_count = 0;

   register_vm_execute_unit_top #(
      .REGISTER_COUNT(REG_COUNT),
      .PROGRAM_WORDS (PROGRAM_END),
      .DATA_BITS     (DATA_WIDTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_dest_reg   (req_dest_reg),
      .req_src1_reg   (req_src1_reg),
      .req_src2_reg   (req_src2_reg),
      .req_immediate  (req_immediate),
      .req_jump_target(req_jump_target),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_ip    (rsp_next_ip),
      .rsp_taken      (rsp_taken),
      .rsp_wrote      (rsp_wrote),
      .rsp_write_value(rsp_write_value),
      .rsp_fault      (rsp_fault)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // In-order shadow of the architectural state.
   function automatic outcome_type execute_instr(instr_type ins);
      outcome_type             o;
      logic [WORD_BITS-1:0]    a;
      logic [WORD_BITS-1:0]    b;
      logic [NEXT_IP_BITS-1:0] dest_ip;
      o = '0;
      a = arch_regs[ins.src1 % REG_COUNT];
      b = arch_regs[ins.src2 % REG_COUNT];
      dest_ip = (ins.target > PROGRAM_END) ? NEXT_IP_BITS'(PROGRAM_END) : ins.target;
      case (ins.op)
         OP_ADD: begin
            o.value = a + b;
            o.wrote = 1'b1;
         end
         OP_ADDI: begin
            o.value = a + ins.imm;
            o.wrote = 1'b1;
         end
         OP_SUB: begin
            o.value = a - b;
            o.wrote = 1'b1;
         end
         OP_MUL: begin
            o.value = a * b;
            o.wrote = 1'b1;
         end
         OP_DIV, OP_REM: begin
            if (b == '0) begin
               o.fault = 1'b1;
            end else begin
               o.value = (ins.op == OP_DIV) ? a / b : a % b;
               o.wrote = 1'b1;
            end
         end
         OP_JUMP: o.taken = 1'b1;
         OP_BEQ:  o.taken = (a == b);
         OP_BNE:  o.taken = (a != b);
         OP_BLT:  o.taken = (a < b);
         OP_BGE:  o.taken = (a >= b);
         default: o.fault = 1'b1;
      endcase
      if (o.fault) begin
         o.next_ip = arch_pc;
      end else if (o.taken) begin
         o.next_ip = dest_ip;
      end else if (int'(arch_pc) + PC_STEP > PROGRAM_END) begin
         o.next_ip = NEXT_IP_BITS'(PROGRAM_END);
      end else begin
         o.next_ip = arch_pc + NEXT_IP_BITS'(PC_STEP);
      end
      if (o.wrote) begin
         arch_regs[ins.dest % REG_COUNT] = o.value;
      end
      arch_pc = o.next_ip;
      return o;
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type row;
      row = '0;
      if ($urandom_range(99) < 4) begin
         row.ins.op = OP_BITS'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      end else begin
         row.ins.op = OP_BITS'($urandom_range(OP_BGE, OP_ADD));
      end
      row.ins.dest = REG_FIELD_BITS'($urandom_range(31));
      row.ins.src1 = REG_FIELD_BITS'($urandom_range(31));
      row.ins.src2 = ($urandom_range(9) == 0) ? row.ins.src1
                                              : REG_FIELD_BITS'($urandom_range(31));
      case ($urandom_range(3))
         0: row.ins.imm = {$urandom, $urandom};
         1: row.ins.imm = WORD_BITS'($urandom_range(255));
         2: row.ins.imm = ~WORD_BITS'($urandom_range(255));
         default: row.ins.imm = WORD_BITS'(1) << $urandom_range(63);
      endcase
      case ($urandom_range(7))
         0: row.ins.target = '0;
         1: row.ins.target = '1;
         default: row.ins.target = TARGET_BITS'($urandom_range(4095));
      endcase
      return row;
   endfunction

   task automatic issue_instr(stim_row_type row);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= row.ins.op;
      req_dest_reg    <= row.ins.dest;
      req_src1_reg    <= row.ins.src1;
      req_src2_reg    <= row.ins.src2;
      req_immediate   <= row.ins.imm;
      req_jump_target <= row.ins.target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = execute_instr(row.ins);
      pending_results.push_back(row.typed ? row.outcome : predicted);
      issued_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: next_ip %0d", rsp_next_ip);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            fault_count += want.fault;
            taken_count += want.taken;
            if (rsp_next_ip !== want.next_ip) begin
               $error("next_ip: expected %0d, got %0d", want.next_ip, rsp_next_ip);
               fail_count++;
            end
            if (rsp_taken !== want.taken) begin
               $error("taken: expected %0b, got %0b", want.taken, rsp_taken);
               fail_count++;
            end
            if (rsp_wrote !== want.wrote) begin
               $error("wrote: expected %0b, got %0b", want.wrote, rsp_wrote);
               fail_count++;
            end
            if (rsp_write_value !== want.value) begin
               $error("write_value: expected %h, got %h", want.value, rsp_write_value);
               fail_count++;
            end
            if (rsp_fault !== want.fault) begin
               $error("fault: expected %0b, got %0b", want.fault, rsp_fault);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int directed_count;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_pc = '0;

      // op, dest, src1, src2, imm, target | typed | next_ip, taken, wrote, value, fault
      directed_rows.push_back('{'{OP_ADDI, 5'd1, 5'd0, 5'd0, ALL_ONES, 12'd0}, 1'b1,
                               '{13'd4, 1'b0, 1'b1, ALL_ONES, 1'b0}});
      directed_rows.push_back('{'{OP_ADDI, 5'd2, 5'd0, 5'd0, 64'd1, 12'd0}, 1'b1,
                               '{13'd8, 1'b0, 1'b1, 64'd1, 1'b0}});
      directed_rows.push_back('{'{OP_ADD, 5'd3, 5'd1, 5'd2, 64'd0, 12'd0}, 1'b1,
                               '{13'd12, 1'b0, 1'b1, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_SUB, 5'd4, 5'd0, 5'd2, 64'd0, 12'd0}, 1'b1,
                               '{13'd16, 1'b0, 1'b1, ALL_ONES, 1'b0}});
      directed_rows.push_back('{'{OP_MUL, 5'd5, 5'd1, 5'd1, 64'd0, 12'd0}, 1'b1,
                               '{13'd20, 1'b0, 1'b1, 64'd1, 1'b0}});
      directed_rows.push_back('{'{OP_DIV, 5'd6, 5'd1, 5'd2, 64'd0, 12'd0}, 1'b1,
                               '{13'd24, 1'b0, 1'b1, ALL_ONES, 1'b0}});
      directed_rows.push_back('{'{OP_REM, 5'd7, 5'd2, 5'd1, 64'd0, 12'd0}, 1'b1,
                               '{13'd28, 1'b0, 1'b1, 64'd1, 1'b0}});
      // divide and remainder by zero
      directed_rows.push_back('{'{OP_DIV, 5'd8, 5'd1, 5'd0, 64'd0, 12'd0}, 1'b1,
                               '{13'd28, 1'b0, 1'b0, 64'd0, 1'b1}});
      directed_rows.push_back('{'{OP_REM, 5'd8, 5'd1, 5'd3, 64'd0, 12'd0}, 1'b1,
                               '{13'd28, 1'b0, 1'b0, 64'd0, 1'b1}});
      // unused opcodes
      directed_rows.push_back('{'{OP_FIRST_UNUSED, 5'd9, 5'd1, 5'd2, 64'd0, 12'd0}, 1'b1,
                               '{13'd28, 1'b0, 1'b0, 64'd0, 1'b1}});
      directed_rows.push_back('{'{OP_LAST_UNUSED, 5'd31, 5'd31, 5'd31, ALL_ONES, 12'd4095},
                               1'b1, '{13'd28, 1'b0, 1'b0, 64'd0, 1'b1}});
      directed_rows.push_back('{'{OP_JUMP, 5'd0, 5'd0, 5'd0, 64'd0, 12'd4095}, 1'b1,
                               '{13'd4095, 1'b1, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_BEQ, 5'd0, 5'd1, 5'd1, 64'd0, 12'd0}, 1'b1,
                               '{13'd0, 1'b1, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_BNE, 5'd0, 5'd1, 5'd1, 64'd0, 12'd77}, 1'b1,
                               '{13'd4, 1'b0, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_BNE, 5'd0, 5'd1, 5'd2, 64'd0, 12'd100}, 1'b1,
                               '{13'd100, 1'b1, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_BLT, 5'd0, 5'd2, 5'd1, 64'd0, 12'd200}, 1'b1,
                               '{13'd200, 1'b1, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_BLT, 5'd0, 5'd1, 5'd2, 64'd0, 12'd300}, 1'b1,
                               '{13'd204, 1'b0, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_BGE, 5'd0, 5'd1, 5'd1, 64'd0, 12'd4092}, 1'b1,
                               '{13'd4092, 1'b1, 1'b0, 64'd0, 1'b0}});
      // counter saturates at the end of the program
      directed_rows.push_back('{'{OP_BGE, 5'd0, 5'd2, 5'd1, 64'd0, 12'd5}, 1'b1,
                               '{13'd4096, 1'b0, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_ADDI, 5'd0, 5'd0, 5'd0, TOP_BIT, 12'd0}, 1'b1,
                               '{13'd4096, 1'b0, 1'b1, TOP_BIT, 1'b0}});
      directed_rows.push_back('{'{OP_ADDI, 5'd31, 5'd3, 5'd0, STRIPES, 12'd0}, 1'b1,
                               '{13'd4096, 1'b0, 1'b1, STRIPES, 1'b0}});
      directed_rows.push_back('{'{OP_MUL, 5'd30, 5'd31, 5'd0, 64'd0, 12'd0}, 1'b0, NO_OUTCOME});
      directed_rows.push_back('{'{OP_JUMP, 5'd0, 5'd0, 5'd0, 64'd0, 12'd0}, 1'b1,
                               '{13'd0, 1'b1, 1'b0, 64'd0, 1'b0}});
      directed_rows.push_back('{'{OP_SUB, 5'd29, 5'd31, 5'd0, 64'd0, 12'd0}, 1'b0, NO_OUTCOME});
      directed_rows.push_back('{'{OP_DIV, 5'd28, 5'd31, 5'd0, 64'd0, 12'd0}, 1'b0, NO_OUTCOME});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) issue_instr(directed_rows[i]);
      directed_count = issued_count;

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 19;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         issue_instr(random_row());
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d instructions issued (%0d directed), %0d results checked",
               issued_count, directed_count, checked_count);
      $display("%0d faults and %0d taken jumps or branches seen", fault_count, taken_count);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/rvm_exec_pkg.sv
sv/rvm_exec_muldiv.sv
sv/register_vm_execute_unit_top.sv
verif/register_vm_execute_unit_top_test.sv
